// ===== design/shpf_pkg.sv =====
// Shared types and constants for the sync/header/payload frame parser.
`timescale 1ns / 1ps
`default_nettype none

package shpf_pkg;

    // Frame phases, one-hot.
    typedef enum logic [3:0] {
        PH_SYNC    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_TRAILER = 4'b1000
    } t_phase;

    // Result codes.
    typedef enum logic [2:0] {
        EV_CONSUMED = 3'd0,
        EV_ACCEPT   = 3'd1,
        EV_REJECT   = 3'd2,
        EV_BYTE     = 3'd3,
        EV_LAST     = 3'd4,
        EV_TRAILER  = 3'd5
    } t_event;

    localparam int unsigned SYNC_LEN    = 8;
    localparam int unsigned HEADER_LEN  = 4;
    localparam logic [63:0] SYNC_RESET  = 64'h4355_4245_5359_4E43;

    // Header byte lanes.
    localparam logic [1:0] HDR_CMD_LO = 2'd0;
    localparam logic [1:0] HDR_CMD_HI = 2'd1;
    localparam logic [1:0] HDR_LEN_LO = 2'd2;
    localparam logic [1:0] HDR_LEN_HI = 2'd3;

    typedef struct packed {
        t_event      event_res;
        logic [15:0] frame_command;
        logic [15:0] frame_length;
        logic [7:0]  payload_byte;
        logic [8:0]  payload_index;
    } t_result;

endpackage

`default_nettype wire

// ===== design/shpf_if.sv =====
// Valid/ready channel interfaces for received bytes and parser results.
`timescale 1ns / 1ps
`default_nettype none

interface shpf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface shpf_res_if;
    logic                 valid;
    logic                 ready;
    shpf_pkg::t_event     event_res;
    logic [15:0]          frame_command;
    logic [15:0]          frame_length;
    logic [7:0]           payload_byte;
    logic [8:0]           payload_index;

    modport source (output valid, output event_res, output frame_command,
                    output frame_length, output payload_byte, output payload_index,
                    input ready);
    modport sink   (input valid, input event_res, input frame_command,
                    input frame_length, input payload_byte, input payload_index,
                    output ready);
endinterface

`default_nettype wire

// ===== design/sync_header_payload_frame_parser.sv =====
// Top level of the sync/header/payload frame parser.
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial deframer. Each received byte beat yields exactly one result beat,
// in the following cycle; a new byte can be taken every cycle while the result
// register is empty or draining. The frame is an 8-byte sync word (i_cfg_data,
// first byte in bits 63:56), then a 4-byte little-endian header (16-bit command,
// 16-bit length), then the payload, then two unchecked trailer bytes. A header
// whose length exceeds MAX_PAYLOAD is reported as rejected and the sync hunt
// restarts. A length of zero still consumes one payload byte, reported as last
// with index 0. During the hunt a mismatching byte restarts the match without
// being retested. Throughput is one byte per clock; the only pipeline element
// is the result register, which accepts a new byte whenever it is empty or
// being drained. Sync pattern writes take effect on the next byte.

module sync_header_payload_frame_parser #(
    parameter int MAX_PAYLOAD = 512
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [63:0]  i_cfg_data,
    shpf_rx_if.sink           i_rx,
    shpf_res_if.source        o_res
);

    localparam int POS_W = (MAX_PAYLOAD > 8) ? $clog2(MAX_PAYLOAD) : 3;

    // Sync word register.
    logic [63:0] r_sync_pattern;

    // Frame state.
    shpf_pkg::t_phase  r_phase, n_phase;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [15:0]       r_cmd, n_cmd;
    logic [15:0]       r_len, n_len;

    // Result register.
    logic               r_valid;
    shpf_pkg::t_result  r_res, n_res;

    logic accept;

    // Take a byte whenever the result register is free or draining this cycle.
    assign i_rx.ready = !r_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;

    shpf_step #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_step (
        .i_phase        (r_phase),
        .i_pos          (r_pos),
        .i_cmd          (r_cmd),
        .i_len          (r_len),
        .i_sync_pattern (r_sync_pattern),
        .i_byte         (i_rx.rx_byte),
        .o_phase        (n_phase),
        .o_pos          (n_pos),
        .o_cmd          (n_cmd),
        .o_len          (n_len),
        .o_result       (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_pattern <= shpf_pkg::SYNC_RESET;
        end else if (i_cfg_we) begin
            r_sync_pattern <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= shpf_pkg::PH_SYNC;
            r_pos   <= '0;
            r_cmd   <= '0;
            r_len   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload side needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.event_res     = r_res.event_res;
    assign o_res.frame_command = r_res.frame_command;
    assign o_res.frame_length  = r_res.frame_length;
    assign o_res.payload_byte  = r_res.payload_byte;
    assign o_res.payload_index = r_res.payload_index;

    // Every accepted byte leaves a result pending.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_valid)
        else $error("accepted byte did not produce a result");

    // Payload position never reaches the limit.
    a_payload_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == shpf_pkg::PH_PAYLOAD) |-> ({1'b0, r_pos} < (POS_W+1)'(MAX_PAYLOAD)))
        else $error("payload position out of range");

    // An accepted header moves the parser into the payload phase.
    a_header_to_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_res.event_res == shpf_pkg::EV_ACCEPT)
            |=> (r_phase == shpf_pkg::PH_PAYLOAD && r_len <= 16'(MAX_PAYLOAD)))
        else $error("header accept did not enter payload phase");

endmodule

`default_nettype wire

// ===== design/shpf_step.sv =====
// Next-state and result logic for one received byte.
`timescale 1ns / 1ps
`default_nettype none

module shpf_step #(
    parameter int MAX_PAYLOAD = 512
) (
    input  wire shpf_pkg::t_phase  i_phase,
    input  wire logic [((MAX_PAYLOAD > 8) ? $clog2(MAX_PAYLOAD) : 3)-1:0] i_pos,
    input  wire logic [15:0]       i_cmd,
    input  wire logic [15:0]       i_len,
    input  wire logic [63:0]       i_sync_pattern,
    input  wire logic [7:0]        i_byte,
    output shpf_pkg::t_phase       o_phase,
    output logic [((MAX_PAYLOAD > 8) ? $clog2(MAX_PAYLOAD) : 3)-1:0] o_pos,
    output logic [15:0]            o_cmd,
    output logic [15:0]            o_len,
    output shpf_pkg::t_result      o_result
);

    localparam int POS_W = (MAX_PAYLOAD > 8) ? $clog2(MAX_PAYLOAD) : 3;

    logic [7:0]       want;
    logic [3:0]       sync_next;
    logic [POS_W:0]   pay_next;
    logic [9:0]       pos_ext;

    assign want      = i_sync_pattern[(3'd7 - i_pos[2:0]) * 8 +: 8];
    assign sync_next = {1'b0, i_pos[2:0]} + 4'd1;
    assign pay_next  = {1'b0, i_pos} + (POS_W+1)'(1);
    assign pos_ext   = 10'(i_pos);

    always_comb begin
        o_phase  = i_phase;
        o_pos    = i_pos;
        o_cmd    = i_cmd;
        o_len    = i_len;
        o_result = '0;
        o_result.event_res = shpf_pkg::EV_CONSUMED;

        unique case (i_phase)
            shpf_pkg::PH_SYNC: begin
                if (i_byte == want) begin
                    if (sync_next == 4'(shpf_pkg::SYNC_LEN)) begin
                        o_phase = shpf_pkg::PH_HEADER;
                        o_pos   = '0;
                    end else begin
                        o_pos = POS_W'(sync_next);
                    end
                end else begin
                    o_pos = '0;   // mismatching byte is not retried as first byte
                end
            end
            shpf_pkg::PH_HEADER: begin
                case (i_pos[1:0])
                    shpf_pkg::HDR_CMD_LO: o_cmd = {i_cmd[15:8], i_byte};
                    shpf_pkg::HDR_CMD_HI: o_cmd = {i_byte, i_cmd[7:0]};
                    shpf_pkg::HDR_LEN_LO: o_len = {i_len[15:8], i_byte};
                    default:              o_len = {i_byte, i_len[7:0]};
                endcase
                if (i_pos[1:0] == 2'(shpf_pkg::HEADER_LEN - 1)) begin
                    o_pos = '0;
                    if (o_len > 16'(MAX_PAYLOAD)) begin
                        o_result.event_res = shpf_pkg::EV_REJECT;
                        o_phase = shpf_pkg::PH_SYNC;
                    end else begin
                        o_result.event_res = shpf_pkg::EV_ACCEPT;
                        o_phase = shpf_pkg::PH_PAYLOAD;
                    end
                end else begin
                    o_pos = POS_W'(i_pos[1:0] + 2'd1);
                end
            end
            shpf_pkg::PH_PAYLOAD: begin
                o_result.payload_byte  = i_byte;
                o_result.payload_index = pos_ext[8:0];
                // zero length still takes one byte and flags it as last
                if (17'(pay_next) >= {1'b0, i_len}) begin
                    o_result.event_res = shpf_pkg::EV_LAST;
                    o_phase = shpf_pkg::PH_TRAILER;
                    o_pos   = '0;
                end else begin
                    o_result.event_res = shpf_pkg::EV_BYTE;
                    o_pos = pay_next[POS_W-1:0];
                end
            end
            default: begin
                if (i_pos[0]) begin
                    o_result.event_res = shpf_pkg::EV_TRAILER;
                    o_phase = shpf_pkg::PH_SYNC;
                    o_pos   = '0;
                end else begin
                    o_pos = POS_W'(1);
                end
            end
        endcase

        o_result.frame_command = o_cmd;
        o_result.frame_length  = o_len;
    end

endmodule

`default_nettype wire
